// File: hw/rtl/bmm_pkg.sv
// package with types and constants for the bipartite matching block
`timescale 1ns / 1ps
package bmm_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  localparam logic CFG_LEFT_COUNT  = 1'b0;
  localparam logic CFG_RIGHT_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_ROOT,
    ST_SCAN,
    ST_VISIT,
    ST_FLIP,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic add_edge;
    logic clear_row;
    logic init_part;
    logic push_root;
    logic scan;
    logic visit;
    logic flip;
    logic emit_load;
    logic next_root;
    logic next_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic init_done;
    logic roots_done;
    logic found;
    logic stack_empty;
    logic free_right;
    logic flip_done;
    logic out_done;
  } stat_t;

endpackage

// File: hw/rtl/bmm_if.sv
// valid/ready channel interfaces for edges, results and configuration
`timescale 1ns / 1ps
interface bmm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] left_vertex;
  logic [4:0] right_vertex;
  modport source (output valid, opcode, left_vertex, right_vertex, input ready);
  modport sink (input valid, opcode, left_vertex, right_vertex, output ready);
endinterface

interface bmm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] right_index;
  logic [4:0] partner;
  logic       is_matched;
  logic [5:0] match_count;
  logic       last;
  modport source (output valid, right_index, partner, is_matched, match_count, last,
                  input ready);
  modport sink (input valid, right_index, partner, is_matched, match_count, last,
                output ready);
endinterface

interface bmm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bmm_ctrl.sv
// controller state machine sequencing load, clear, search and emit
`timescale 1ns / 1ps
module bmm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  input  logic             out_free,
  input  bmm_pkg::stat_t   stat,
  output bmm_pkg::cmd_t    cmd
);
  bmm_pkg::state_t state, state_next;
  logic take;

  assign take = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bmm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmm_pkg::ST_IDLE: begin
        if (take && in_opcode == bmm_pkg::OP_CLEAR) state_next = bmm_pkg::ST_CLEAR;
        else if (take && in_opcode == bmm_pkg::OP_SOLVE) state_next = bmm_pkg::ST_INIT;
      end
      bmm_pkg::ST_CLEAR: if (stat.clear_done) state_next = bmm_pkg::ST_IDLE;
      bmm_pkg::ST_INIT:  if (stat.init_done) state_next = bmm_pkg::ST_ROOT;
      bmm_pkg::ST_ROOT:  state_next = stat.roots_done ? bmm_pkg::ST_EMIT : bmm_pkg::ST_SCAN;
      bmm_pkg::ST_SCAN: begin
        if (stat.stack_empty) state_next = bmm_pkg::ST_ROOT;
        else if (stat.found) state_next = bmm_pkg::ST_VISIT;
      end
      bmm_pkg::ST_VISIT: state_next = stat.free_right ? bmm_pkg::ST_FLIP : bmm_pkg::ST_SCAN;
      bmm_pkg::ST_FLIP:  if (stat.flip_done) state_next = bmm_pkg::ST_ROOT;
      bmm_pkg::ST_EMIT:  if (out_free && stat.out_done) state_next = bmm_pkg::ST_IDLE;
      default: state_next = bmm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      bmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.add_edge = take && in_opcode == bmm_pkg::OP_ADD;
      end
      bmm_pkg::ST_CLEAR: cmd.clear_row = 1'b1;
      bmm_pkg::ST_INIT:  cmd.init_part = 1'b1;
      bmm_pkg::ST_ROOT:  cmd.push_root = !stat.roots_done;
      bmm_pkg::ST_SCAN: begin
        cmd.scan = !stat.stack_empty;
        cmd.next_root = stat.stack_empty;
      end
      bmm_pkg::ST_VISIT: cmd.visit = 1'b1;
      bmm_pkg::ST_FLIP: begin
        cmd.flip = 1'b1;
        cmd.next_root = stat.flip_done;
      end
      bmm_pkg::ST_EMIT: begin
        cmd.emit_load = out_free;
        cmd.next_out = out_free;
      end
      default: cmd = '0;
    endcase
  end
endmodule

// File: hw/rtl/bmm_dp.sv
// datapath: adjacency rows, partner table, visited marks and search stack
`timescale 1ns / 1ps
module bmm_dp #(
  parameter int MAX_LEFT  = 32,
  parameter int MAX_RIGHT = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  bmm_pkg::cmd_t   cmd,
  output bmm_pkg::stat_t  stat,
  input  logic [4:0]      in_left,
  input  logic [4:0]      in_right,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [5:0]      cfg_data,
  output logic [4:0]      res_right,
  output logic [4:0]      res_partner,
  output logic            res_matched,
  output logic [5:0]      res_count,
  output logic            res_last
);
  localparam int LW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
  localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
  localparam int LCW = $clog2(MAX_LEFT + 1);
  localparam int RCW = $clog2(MAX_RIGHT + 1);
  localparam int SW = (LCW > RCW) ? LCW : RCW;

  logic [MAX_RIGHT-1:0] adj [MAX_LEFT];
  logic [LW-1:0]        ptab [MAX_RIGHT];
  logic [MAX_RIGHT-1:0] pvalid;
  logic [MAX_RIGHT-1:0] visited;
  logic [LW-1:0]        stk_left [MAX_LEFT];
  logic [RCW-1:0]       stk_next [MAX_LEFT];
  logic [LCW-1:0]       depth;
  logic [LCW-1:0]       root;
  logic [5:0]           matched_total;
  logic [5:0]           left_count, right_count;
  logic [LCW-1:0]       lc;
  logic [RCW-1:0]       rc;
  logic [SW-1:0]        sweep;
  logic [RW-1:0]        hit_v;
  logic                 hit;
  logic [RW-1:0]        cur_v;
  logic [LW-1:0]        top_left;
  logic [RCW-1:0]       top_next;
  logic [MAX_RIGHT-1:0] cand;
  logic [LCW-1:0]       top_idx;

  // clamped counts
  always_comb begin
    if (left_count == 6'd0) lc = LCW'(1);
    else if (32'(left_count) > MAX_LEFT) lc = LCW'(MAX_LEFT);
    else lc = LCW'(left_count);
    if (right_count == 6'd0) rc = RCW'(1);
    else if (32'(right_count) > MAX_RIGHT) rc = RCW'(MAX_RIGHT);
    else rc = RCW'(right_count);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= 6'(MAX_LEFT > 63 ? 63 : MAX_LEFT);
      right_count <= 6'(MAX_RIGHT > 63 ? 63 : MAX_RIGHT);
    end else if (cfg_we) begin
      if (cfg_index == bmm_pkg::CFG_LEFT_COUNT) left_count <= cfg_data;
      else right_count <= cfg_data;
    end
  end

  // top frame and first eligible neighbour at or after next
  assign top_idx  = depth - LCW'(1);
  assign top_left = stk_left[top_idx[LW-1:0]];
  assign top_next = stk_next[top_idx[LW-1:0]];
  always_comb begin
    hit = 1'b0;
    hit_v = '0;
    for (int i = 0; i < MAX_RIGHT; i++) begin
      cand[i] = adj[top_left][i] && !visited[i] && (RCW'(i) >= top_next) &&
                (RCW'(i) < rc) && (LCW'(top_left) < lc);
    end
    for (int i = MAX_RIGHT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit = 1'b1;
        hit_v = RW'(i);
      end
    end
  end

  assign stat.found       = hit;
  assign stat.stack_empty = (depth == '0);
  assign stat.roots_done  = (root >= lc);
  assign stat.clear_done  = (sweep == SW'(MAX_LEFT - 1));
  assign stat.init_done   = 1'b1;
  assign stat.free_right  = !pvalid[cur_v];
  assign stat.flip_done   = (depth == LCW'(1));
  assign stat.out_done    = (RCW'(sweep) == rc - RCW'(1));

  // adjacency matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEFT; i++) adj[i] <= '0;
    end else if (cmd.add_edge) begin
      if (32'(in_left) < MAX_LEFT && 32'(in_right) < MAX_RIGHT)
        adj[LW'(in_left)][RW'(in_right)] <= 1'b1;
    end else if (cmd.clear_row) begin
      adj[sweep[LW-1:0]] <= '0;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      root <= '0;
      sweep <= '0;
      pvalid <= '0;
      visited <= '0;
      matched_total <= '0;
      cur_v <= '0;
    end else begin
      if (cmd.clear_row) sweep <= stat.clear_done ? '0 : sweep + SW'(1);
      if (cmd.init_part) begin
        pvalid <= '0;
        root <= '0;
        matched_total <= '0;
        sweep <= '0;
      end
      if (cmd.push_root) begin
        visited <= '0;
        stk_left[0] <= root[LW-1:0];
        stk_next[0] <= '0;
        depth <= LCW'(1);
      end
      if (cmd.scan) begin
        if (hit) begin
          visited[hit_v] <= 1'b1;
          stk_next[top_idx[LW-1:0]] <= RCW'(hit_v) + RCW'(1);
          cur_v <= hit_v;
        end else begin
          depth <= depth - LCW'(1);
        end
      end
      if (cmd.visit && pvalid[cur_v] && depth < LCW'(MAX_LEFT)) begin
        stk_left[depth[LW-1:0]] <= ptab[cur_v];
        stk_next[depth[LW-1:0]] <= '0;
        depth <= depth + LCW'(1);
      end
      if (cmd.flip) begin
        pvalid[RW'(top_next - RCW'(1))] <= 1'b1;
        ptab[RW'(top_next - RCW'(1))] <= top_left;
        depth <= depth - LCW'(1);
        if (stat.flip_done) matched_total <= matched_total + 6'd1;
      end
      if (cmd.next_root) root <= root + LCW'(1);
      if (cmd.next_out) sweep <= stat.out_done ? '0 : sweep + SW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      res_right   <= 5'(sweep);
      res_matched <= pvalid[sweep[RW-1:0]];
      res_partner <= pvalid[sweep[RW-1:0]] ? 5'(ptab[sweep[RW-1:0]]) : 5'd0;
      res_last    <= stat.out_done;
      res_count   <= stat.out_done ? matched_total : 6'd0;
    end
  end
endmodule

// File: hw/rtl/bipartite_max_matching.sv
// top level of the bipartite maximum matching block
`timescale 1ns / 1ps
// Maximum bipartite matching by augmenting paths.
// Channel in carries commands: add edge, clear all edges (all MAX_LEFT rows,
// one adjacency row per cycle) and solve.
// Channel cfg writes left_count (index 0) and right_count (index 1);
// counts of 0 act as 1, counts above the maximum act as the maximum.
// A solve first resets partners, then for each left vertex pushes it as
// root, scans for and visits each reachable unvisited right vertex, pops
// each failed frame and flips each step of a found augmenting path; a root
// whose search fails ends on seeing the empty stack. A final root step ends
// the search, and the emit state then loads results into the output
// register; without stalls results then move one per cycle.
// Results, one per right vertex in use, leave through an output register
// on channel out; last marks the final one, which carries the matching size.
// Input ready is low from a solve until its last result is loaded into the
// output register; a stalled receiver simply holds the output register and
// the controller.
// Reset (rst, synchronous) empties the edge matrix, unmatches all right
// vertices and restores both counts to their maxima.
module bipartite_max_matching #(
  parameter int MAX_LEFT  = 32,
  parameter int MAX_RIGHT = 32
) (
  input logic clk,
  input logic rst,
  bmm_in_if.sink    in,
  bmm_out_if.source out,
  bmm_cfg_if.sink   cfg
);
  bmm_pkg::cmd_t  cmd;
  bmm_pkg::stat_t stat;
  logic out_free;

  assign cfg.ready = 1'b1;
  assign out_free = !out.valid || out.ready;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (cmd.emit_load) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end

  bmm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_opcode(in.opcode),
    .in_ready(in.ready), .out_free(out_free), .stat(stat), .cmd(cmd)
  );

  bmm_dp #(.MAX_LEFT(MAX_LEFT), .MAX_RIGHT(MAX_RIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_left(in.left_vertex), .in_right(in.right_vertex),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .res_right(out.right_index), .res_partner(out.partner),
    .res_matched(out.is_matched), .res_count(out.match_count), .res_last(out.last)
  );
endmodule
